// ----- rtl/core/shpl_pkg.sv -----
// Shared constants, payload types and the LFSR step for the shuffle playlist sequencer.
package shpl_pkg;

  localparam int CNT_W         = 5;
  localparam int SLOT_W        = 4;
  localparam int LFSR_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_MAX_SLOTS = 16;
  localparam int MOD_BITS      = 4;
  localparam int MOD_STEPS     = LFSR_W / MOD_BITS;
  localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FOREVER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED    = 2'd3;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  typedef struct packed {
    logic func;
    logic player_playing;
    logic player_accepts;
  } in_item_t;

  typedef struct packed {
    logic              start_request;
    logic [SLOT_W-1:0] slot_number;
    logic              pause_request;
    logic              status_light;
    logic              done_flag;
    logic              start_ok;
  } out_item_t;

  // One shift of the right-shifting Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] nxt;
    nxt = v >> 1;
    if (v[0]) nxt = nxt ^ LFSR_TAPS;
    return nxt;
  endfunction

endpackage

// ----- rtl/core/shuffle_playlist_sequencer_unit.sv -----
// Each shuffle swap costs one LFSR draw, eight 4-bit remainder steps and four
// order-table accesses through the order RAM. One request is handled at a time;
// a finished result waits in the output register while the next request is taken.
// Reset is synchronous: the state, configuration and status registers and rsp_valid clear, the LFSR loads 1.
module shuffle_playlist_sequencer_unit #(
  parameter int MAX_SLOTS = shpl_pkg::DEF_MAX_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  shpl_pkg::in_item_t                  cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output shpl_pkg::out_item_t                 rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shpl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shpl_pkg::LFSR_W-1:0]         cfg_data
);

  localparam int CNT_W  = shpl_pkg::CNT_W;
  localparam int SLOT_W = shpl_pkg::SLOT_W;
  localparam int LFSR_W = shpl_pkg::LFSR_W;
  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int WIDE_W = CNT_W + IDX_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_DRAW = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_RDHI = 4'd4;
  localparam logic [3:0] S_RDJ  = 4'd5;
  localparam logic [3:0] S_WHI  = 4'd6;
  localparam logic [3:0] S_WJ   = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;
  localparam logic [3:0] S_TRY  = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0]        state;
  logic [CNT_W-1:0]  slot_count;
  logic              shuffle_mode;
  logic              repeat_forever;
  logic [LFSR_W-1:0] lfsr;
  logic [CNT_W-1:0]  pos;
  logic              sound_started;
  logic              was_playing;
  logic              piece_done;
  logic              light_level;

  logic              accepts_l;
  logic              is_start;
  logic              res_started;
  logic [SLOT_W-1:0] res_slot;
  logic              res_paused;

  logic [CNT_W-1:0]  fill_k;
  logic [CNT_W-1:0]  div_i;
  logic [LFSR_W-1:0] dividend;
  logic [CNT_W-1:0]  rem;
  logic [shpl_pkg::MOD_CNT_W-1:0] mod_cnt;
  logic [IDX_W-1:0]  swap_tmp;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  hi_k;
  logic [WIDE_W-1:0] fill_wide, pos_wide, hi_wide, j_wide;
  logic [IDX_W-1:0]  fill_idx, pos_idx, hi_idx, j_idx;
  logic [SLOT_W+IDX_W-1:0] slot_wide;
  logic [SLOT_W-1:0] slot_val;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]  mod_r;
  logic [LFSR_W-1:0] mod_d;

  // Slot counts above the table depth are used as the depth.
  assign n = (32'(slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot_count;
  assign hi_k = div_i - CNT_W'(1);

  assign fill_wide = {{IDX_W{1'b0}}, fill_k};
  assign pos_wide  = {{IDX_W{1'b0}}, pos};
  assign hi_wide   = {{IDX_W{1'b0}}, hi_k};
  assign j_wide    = {{IDX_W{1'b0}}, rem};
  assign fill_idx  = fill_wide[IDX_W-1:0];
  assign pos_idx   = pos_wide[IDX_W-1:0];
  assign hi_idx    = hi_wide[IDX_W-1:0];
  assign j_idx     = j_wide[IDX_W-1:0];
  assign slot_wide = {{SLOT_W{1'b0}}, ram_rdata};
  assign slot_val  = slot_wide[SLOT_W-1:0];

  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Four restoring remainder steps per cycle; the divisor never exceeds 31.
  always_comb begin : mod_step
    logic [CNT_W:0]    r;
    logic [LFSR_W-1:0] d;
    r = {1'b0, rem};
    d = dividend;
    for (int b = 0; b < shpl_pkg::MOD_BITS; b++) begin
      r = {r[CNT_W-1:0], d[LFSR_W-1]};
      d = d << 1;
      if (r >= {1'b0, div_i}) r = r - {1'b0, div_i};
    end
    mod_r = r[CNT_W-1:0];
    mod_d = d;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_idx;
    ram_wdata = fill_idx;
    ram_raddr = pos_idx;
    unique case (state)
      S_FILL: begin
        ram_we = (fill_k < n);
      end
      S_RDHI: begin
        ram_raddr = hi_idx;
      end
      S_RDJ: begin
        ram_raddr = j_idx;
      end
      S_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_idx;
        ram_wdata = ram_rdata;
      end
      S_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_idx;
        ram_wdata = swap_tmp;
      end
      default: begin
        ram_raddr = pos_idx;
      end
    endcase
  end

  shpl_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_SLOTS)
  ) u_order_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_count     <= '0;
      shuffle_mode   <= 1'b0;
      repeat_forever <= 1'b0;
      lfsr           <= LFSR_W'(1);
      pos            <= '0;
      sound_started  <= 1'b0;
      was_playing    <= 1'b0;
      piece_done     <= 1'b0;
      light_level    <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      // The emit state reloads the output register itself when it is drained.
      if (rsp_valid && rsp_ready && (state != S_EMIT)) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            accepts_l   <= cmd.player_accepts;
            res_started <= 1'b0;
            res_slot    <= '0;
            res_paused  <= 1'b0;
            is_start    <= 1'b0;
            if (cmd.func == shpl_pkg::FUNC_START) begin
              if (n == '0) begin
                piece_done <= 1'b1;
                state      <= S_EMIT;
              end else begin
                pos           <= '0;
                sound_started <= 1'b0;
                piece_done    <= 1'b0;
                was_playing   <= 1'b0;
                is_start      <= 1'b1;
                fill_k        <= '0;
                state         <= S_FILL;
              end
            end else if (piece_done) begin
              state <= S_EMIT;
            end else if (sound_started && was_playing && !cmd.player_playing) begin
              // The sound that was started has ended: pause and move on.
              res_paused <= 1'b1;
              state      <= S_ADV;
            end else begin
              was_playing <= cmd.player_playing;
              light_level <= cmd.player_playing;
              state       <= S_EMIT;
            end
          end
        end
        S_FILL: begin
          if (fill_k < n) begin
            fill_k <= fill_k + CNT_W'(1);
          end else if (shuffle_mode && (n > CNT_W'(1))) begin
            div_i <= n;
            state <= S_DRAW;
          end else begin
            state <= S_TRY;
          end
        end
        S_DRAW: begin
          lfsr     <= shpl_pkg::lfsr_step(lfsr);
          dividend <= shpl_pkg::lfsr_step(lfsr);
          rem      <= '0;
          mod_cnt  <= '0;
          state    <= S_MOD;
        end
        S_MOD: begin
          dividend <= mod_d;
          rem      <= mod_r;
          mod_cnt  <= mod_cnt + shpl_pkg::MOD_CNT_W'(1);
          if (mod_cnt == shpl_pkg::MOD_CNT_W'(shpl_pkg::MOD_STEPS - 1)) state <= S_RDHI;
        end
        S_RDHI: begin
          state <= S_RDJ;
        end
        S_RDJ: begin
          swap_tmp <= ram_rdata;
          state    <= S_WHI;
        end
        S_WHI: begin
          state <= S_WJ;
        end
        S_WJ: begin
          div_i <= hi_k;
          if (div_i > CNT_W'(2)) state <= S_DRAW;
          else state <= S_TRY;
        end
        S_ADV: begin
          if (pos >= n) begin
            if (repeat_forever) begin
              pos    <= '0;
              fill_k <= '0;
              state  <= S_FILL;
            end else begin
              piece_done  <= 1'b1;
              light_level <= 1'b0;
              state       <= S_EMIT;
            end
          end else begin
            state <= S_TRY;
          end
        end
        S_TRY: begin
          if (!accepts_l) begin
            light_level <= 1'b0;
            state       <= S_EMIT;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          res_started   <= 1'b1;
          res_slot      <= slot_val;
          light_level   <= 1'b1;
          sound_started <= 1'b1;
          was_playing   <= 1'b1;
          pos           <= pos + CNT_W'(1);
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.start_request <= res_started;
            rsp.slot_number   <= res_slot;
            rsp.pause_request <= res_paused;
            rsp.status_light  <= light_level;
            rsp.done_flag     <= piece_done;
            rsp.start_ok      <= res_started & is_start;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_valid) begin
        unique case (cfg_index)
          shpl_pkg::REG_SLOT_COUNT:     slot_count     <= cfg_data[CNT_W-1:0];
          shpl_pkg::REG_SHUFFLE_MODE:   shuffle_mode   <= cfg_data[0];
          shpl_pkg::REG_REPEAT_FOREVER: repeat_forever <= cfg_data[0];
          shpl_pkg::REG_RANDOM_SEED:    lfsr <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("sequencer still ready after taking a request");

  a_start_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.start_request |-> rsp.status_light && !rsp.done_flag)
    else $error("started slot reported with light off or playlist done");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("shuffle LFSR reached the all-zero lockup state");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD |-> rem < div_i)
    else $error("partial remainder not below the divisor");
`endif

endmodule

// ----- rtl/core/shpl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module shpl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
